### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the stable priority queue
// Default sizes, operation and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH   = 16;
	localparam int DEFAULT_ID_BITS       = 16;
	localparam int DEFAULT_PRIORITY_BITS = 32;

	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIND = 2'd2;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd3;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one queue slot
// Holds one identifier and its priority; takes its neighbor's entry on a
// shift and the pushed entry on a load.
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int ID_BITS       = spq_pkg::DEFAULT_ID_BITS,
	parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS
) (
	input  logic                     clk,
	input  spq_pkg::cell_ctrl_t      ctrl,
	input  logic [ID_BITS-1:0]       nbr_id,
	input  logic [PRIORITY_BITS-1:0] nbr_prio,
	input  logic [ID_BITS-1:0]       push_id,
	input  logic [PRIORITY_BITS-1:0] push_prio,
	output logic [ID_BITS-1:0]       id,
	output logic [PRIORITY_BITS-1:0] prio
);

	logic [ID_BITS-1:0]       id_q;
	logic [PRIORITY_BITS-1:0] prio_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			id_q   <= push_id;
			prio_q <= push_prio;
		end else if (ctrl.shift) begin
			id_q   <= nbr_id;
			prio_q <= nbr_prio;
		end
	end

	assign id   = id_q;
	assign prio = prio_q;

endmodule

### design/spq_scan.sv
// ----------------------------------------------------------------------------
// spq_scan: head-of-ring compare unit
// Watches the entry at the ring head while the ring rotates, recording
// whether the key is present and which entry has the smallest priority.
// ----------------------------------------------------------------------------
module spq_scan #(
	parameter int QUEUE_DEPTH   = spq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int ID_BITS       = spq_pkg::DEFAULT_ID_BITS,
	parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS,
	localparam int IDX_W        = $clog2(QUEUE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     step_en,
	input  logic [IDX_W-1:0]         step,
	input  logic [ID_BITS-1:0]       head_id,
	input  logic [PRIORITY_BITS-1:0] head_prio,
	input  logic [ID_BITS-1:0]       key_id,
	output logic                     hit,
	output logic [IDX_W-1:0]         best_idx,
	output logic [ID_BITS-1:0]       best_id
);

	logic                     hit_q;
	logic                     best_ok_q;
	logic [IDX_W-1:0]         best_idx_q;
	logic [ID_BITS-1:0]       best_id_q;
	logic [PRIORITY_BITS-1:0] best_prio_q;
	logic                     take;

	assign take = step_en && (!best_ok_q || (head_prio < best_prio_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			best_ok_q <= 1'b0;
		end else if (start) begin
			hit_q     <= 1'b0;
			best_ok_q <= 1'b0;
		end else if (step_en) begin
			if (head_id == key_id) begin
				hit_q <= 1'b1;
			end
			best_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= step;
			best_id_q   <= head_id;
			best_prio_q <= head_prio;
		end
	end

	assign hit      = hit_q;
	assign best_idx = best_idx_q;
	assign best_id  = best_id_q;

endmodule

### design/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded min-priority queue of requester identifiers
// Entries sit in a ring of cells in push order. Each operation rotates the
// ring once past a compare unit, then pushes, pops with compaction, or
// reports a find.
// ----------------------------------------------------------------------------
// Channel   Direction  Fields (lowest bit first)
// s_*       in         mode, requester_id, priority_req
// m_*       out        status, popped_id, found, empty_res, occupancy
//
// An operation accepts the beat, rotates the ring by one step for each cell,
// and then updates the cells and loads the result.
// The rotation length is set by the number of cells, not by the occupancy.
// Reset empties the queue; cell contents are left as they are.
// A new beat is taken while a result waits; a stalled result holds only the
// final update step.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
	parameter int QUEUE_DEPTH   = spq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int ID_BITS       = spq_pkg::DEFAULT_ID_BITS,
	parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS,
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
	localparam int IN_BITS      = spq_pkg::MODE_W + ID_BITS + PRIORITY_BITS,
	localparam int IN_W         = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS     = spq_pkg::STATUS_W + ID_BITS + 2 + CNT_W,
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// mode, requester_id, priority_req
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// status, popped_id, found, empty_res, occupancy
	output logic [OUT_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;

	logic [1:0]                      state_q;
	logic [IDX_W-1:0]                step_q;
	logic [CNT_W-1:0]                count_q;
	logic [CNT_W-1:0]                count_nxt;
	logic [spq_pkg::MODE_W-1:0]      mode_q;
	logic [ID_BITS-1:0]              key_id_q;
	logic [PRIORITY_BITS-1:0]        key_prio_q;

	logic                            in_fire;
	logic                            apply_go;
	logic                            scanning;
	logic                            step_en;
	logic                            hit;
	logic [IDX_W-1:0]                best_idx;
	logic [ID_BITS-1:0]              best_id;
	logic                            push_ok;
	logic                            pop_ok;

	logic [spq_pkg::STATUS_W-1:0]    status_nxt;
	logic [ID_BITS-1:0]              popped_nxt;
	logic                            found_nxt;

	logic                            m_tvalid_q;
	logic [spq_pkg::STATUS_W-1:0]    status_q;
	logic [ID_BITS-1:0]              popped_q;
	logic                            found_q;
	logic                            empty_q;
	logic [CNT_W-1:0]                occ_q;

	logic [ID_BITS-1:0]              cell_id   [QUEUE_DEPTH];
	logic [PRIORITY_BITS-1:0]        cell_prio [QUEUE_DEPTH];
	spq_pkg::cell_ctrl_t             cell_ctrl [QUEUE_DEPTH];

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign scanning = (state_q == ST_SCAN);
	assign step_en  = scanning && (CNT_W'(step_q) < count_q);
	assign apply_go = (state_q == ST_APPLY) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						step_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (step_q == IDX_W'(QUEUE_DEPTH - 1)) begin
						state_q <= ST_APPLY;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_APPLY: begin
					if (apply_go) begin
						count_q <= count_nxt;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q     <= s_tdata[spq_pkg::MODE_W-1:0];
			key_id_q   <= s_tdata[spq_pkg::MODE_W +: ID_BITS];
			key_prio_q <= s_tdata[spq_pkg::MODE_W + ID_BITS +: PRIORITY_BITS];
		end
	end

	spq_scan #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.ID_BITS      (ID_BITS),
		.PRIORITY_BITS(PRIORITY_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.step_en  (step_en),
		.step     (step_q),
		.head_id  (cell_id[0]),
		.head_prio(cell_prio[0]),
		.key_id   (key_id_q),
		.hit      (hit),
		.best_idx (best_idx),
		.best_id  (best_id)
	);

	assign push_ok = (mode_q == spq_pkg::MODE_PUSH) && !hit &&
	                 (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_ok  = (mode_q == spq_pkg::MODE_POP) && (count_q != '0);

	always_comb begin
		status_nxt = spq_pkg::STATUS_OK;
		popped_nxt = '0;
		found_nxt  = 1'b0;
		count_nxt  = count_q;
		case (mode_q)
			spq_pkg::MODE_PUSH: begin
				if (hit) begin
					status_nxt = spq_pkg::STATUS_DUPLICATE;
				end else if (!push_ok) begin
					status_nxt = spq_pkg::STATUS_PUSH_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			spq_pkg::MODE_POP: begin
				if (!pop_ok) begin
					status_nxt = spq_pkg::STATUS_POP_EMPTY;
				end else begin
					popped_nxt = best_id;
					count_nxt  = count_q - 1'b1;
				end
			end
			spq_pkg::MODE_FIND: begin
				found_nxt = hit;
			end
			default: begin
				status_nxt = spq_pkg::STATUS_OK;
			end
		endcase
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int NBR = (i + 1) % QUEUE_DEPTH;

		assign cell_ctrl[i] = '{
			shift: scanning || (apply_go && pop_ok && (IDX_W'(i) >= best_idx)),
			load:  apply_go && push_ok && (CNT_W'(i) == count_q)
		};

		spq_cell #(
			.ID_BITS      (ID_BITS),
			.PRIORITY_BITS(PRIORITY_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.nbr_id   (cell_id[NBR]),
			.nbr_prio (cell_prio[NBR]),
			.push_id  (key_id_q),
			.push_prio(key_prio_q),
			.id       (cell_id[i]),
			.prio     (cell_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (apply_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			status_q <= status_nxt;
			popped_q <= popped_nxt;
			found_q  <= found_nxt;
			empty_q  <= (count_nxt == '0);
			occ_q    <= count_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({occ_q, empty_q, found_q, popped_q, status_q});

endmodule

### design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the stable priority queue
// Watches the result stream for holding rules and field consistency, and the input side for busy handling.
// ----------------------------------------------------------------------------
module spq_checker #(
	parameter int QUEUE_DEPTH   = spq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int ID_BITS       = spq_pkg::DEFAULT_ID_BITS,
	parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS,
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1),
	localparam int OUT_BITS     = spq_pkg::STATUS_W + ID_BITS + 2 + CNT_W,
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int POP_LO   = spq_pkg::STATUS_W;
	localparam int FOUND_B  = POP_LO + ID_BITS;
	localparam int EMPTY_B  = FOUND_B + 1;
	localparam int OCC_LO   = EMPTY_B + 1;

	logic [spq_pkg::STATUS_W-1:0] status;
	logic [ID_BITS-1:0]           popped;
	logic                         found;
	logic                         empty;
	logic [CNT_W-1:0]             occ;

	assign status = m_tdata[spq_pkg::STATUS_W-1:0];
	assign popped = m_tdata[POP_LO +: ID_BITS];
	assign found  = m_tdata[FOUND_B];
	assign empty  = m_tdata[EMPTY_B];
	assign occ    = m_tdata[OCC_LO +: CNT_W];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result beat dropped while stalled.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Result beat changed while stalled.");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (occ <= CNT_W'(QUEUE_DEPTH)) && (empty == (occ == '0)))
		else $error("Occupancy out of range or empty flag inconsistent.");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status != spq_pkg::STATUS_OK) |-> (popped == '0) && !found)
		else $error("Failed operation reports a popped identifier or a match.");

	a_status_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
			((status != spq_pkg::STATUS_PUSH_FULL) || (occ == CNT_W'(QUEUE_DEPTH))) &&
			((status != spq_pkg::STATUS_POP_EMPTY) || empty))
		else $error("Full or empty status disagrees with the occupancy.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted again while an operation is in progress.");

endmodule

bind stable_priority_queue spq_checker #(
	.QUEUE_DEPTH  (QUEUE_DEPTH),
	.ID_BITS      (ID_BITS),
	.PRIORITY_BITS(PRIORITY_BITS)
) u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

### tb/stable_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: self-checking bench for the stable priority queue
// A short table of directed operations covers empty, full, duplicate, tied and
// unused-mode cases. Random push, pop, find and unused-mode traffic follows, alternating
// between filling and draining phases. Every accepted operation goes through
// an in-bench queue predictor, and each result beat is compared field by field.
// Both stream sides insert random idle cycles, with some stretches at full rate.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;

	localparam int QDEPTH       = spq_pkg::DEFAULT_QUEUE_DEPTH;
	localparam int ID_W         = spq_pkg::DEFAULT_ID_BITS;
	localparam int PRIO_W       = spq_pkg::DEFAULT_PRIORITY_BITS;
	localparam int MODE_W       = spq_pkg::MODE_W;
	localparam int STATUS_W     = spq_pkg::STATUS_W;
	localparam int CNT_W        = $clog2(QDEPTH + 1);
	localparam int IN_BITS      = MODE_W + ID_W + PRIO_W;
	localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS     = STATUS_W + ID_W + 2 + CNT_W;
	localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1925;
	localparam int PHASE_LEN    = 150;
	localparam int MAX_WAIT     = 18;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = QDEPTH + 2 + 8;
	localparam int POOL_SIZE    = 24;
	localparam int PRINT_LIMIT  = 100;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} op_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     popped_id;
		logic                found;
		logic                empty_res;
		logic [CNT_W-1:0]    occupancy;
	} result_t;

	typedef struct {
		op_t     op;
		bit      typed;
		result_t want;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	logic [ID_W-1:0]   held_ids [QDEPTH];
	logic [PRIO_W-1:0] held_prios [QDEPTH];
	int                held_count = 0;

	result_t    pending_results [$];
	row_t       directed [$];
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	int  mismatches = 0;
	int  stalled_cycles = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b0;
	int  n_push = 0, n_pop = 0, n_find = 0, n_other = 0;
	int  n_full = 0, n_dup = 0, n_empty_pop = 0, n_hit = 0, peak_occ = 0;

	always #1 clk = ~clk;

	stable_priority_queue #(
		.QUEUE_DEPTH(QDEPTH),
		.ID_BITS(ID_W),
		.PRIORITY_BITS(PRIO_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	// Entries are held oldest first, so the first minimum found is the oldest one.
	function automatic result_t queue_predict(op_t op);
		result_t r;
		int      at;
		int      best;
		r = '0;
		at = -1;
		for (int i = 0; i < held_count; i++) begin
			if (at < 0 && held_ids[i] == op.id) at = i;
		end
		case (op.mode)
			spq_pkg::MODE_PUSH: begin
				n_push++;
				if (at >= 0) begin
					r.status = spq_pkg::STATUS_DUPLICATE;
					n_dup++;
				end else if (held_count >= QDEPTH) begin
					r.status = spq_pkg::STATUS_PUSH_FULL;
					n_full++;
				end else begin
					held_ids[held_count] = op.id;
					held_prios[held_count] = op.prio;
					held_count++;
				end
			end
			spq_pkg::MODE_POP: begin
				n_pop++;
				if (held_count == 0) begin
					r.status = spq_pkg::STATUS_POP_EMPTY;
					n_empty_pop++;
				end else begin
					best = 0;
					for (int i = 1; i < held_count; i++) begin
						if (held_prios[i] < held_prios[best]) best = i;
					end
					r.popped_id = held_ids[best];
					for (int i = best; i < held_count - 1; i++) begin
						held_ids[i] = held_ids[i + 1];
						held_prios[i] = held_prios[i + 1];
					end
					held_count--;
				end
			end
			spq_pkg::MODE_FIND: begin
				n_find++;
				r.found = (at >= 0);
				if (at >= 0) n_hit++;
			end
			default: begin
				n_other++;
			end
		endcase
		r.empty_res = (held_count == 0);
		r.occupancy = CNT_W'(held_count);
		if (held_count > peak_occ) peak_occ = held_count;
		return r;
	endfunction

	function automatic void add_row(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
			logic [PRIO_W-1:0] prio, bit typed = 1'b0, result_t want = '0);
		row_t r;
		r.op.mode = mode;
		r.op.id = id;
		r.op.prio = prio;
		r.typed = typed;
		r.want = want;
		directed.push_back(r);
	endfunction

	task automatic send_op(op_t op, bit typed, result_t want);
		int      gap;
		result_t model;
		gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'({op.prio, op.id, op.mode});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		model = queue_predict(op);
		pending_results.push_back(typed ? want : model);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stalled_cycles <= 0;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
				if (stalled_cycles >= IDLE_LIMIT) begin
					$display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
					$display("Verification failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int      stall;
		int      seen;
		result_t got;
		result_t want;
		seen = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (seen % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
			stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			seen++;
			got.status = m_tdata[STATUS_W-1:0];
			got.popped_id = m_tdata[STATUS_W +: ID_W];
			got.found = m_tdata[STATUS_W + ID_W];
			got.empty_res = m_tdata[STATUS_W + ID_W + 1];
			got.occupancy = m_tdata[STATUS_W + ID_W + 2 +: CNT_W];
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat %0d with nothing expected: %h",
					seen, m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("beat %0d status %0d, expected %0d",
						seen, got.status, want.status));
				if (got.popped_id !== want.popped_id)
					report_mismatch($sformatf("beat %0d popped_id %h, expected %h",
						seen, got.popped_id, want.popped_id));
				if (got.found !== want.found)
					report_mismatch($sformatf("beat %0d found %b, expected %b",
						seen, got.found, want.found));
				if (got.empty_res !== want.empty_res)
					report_mismatch($sformatf("beat %0d empty_res %b, expected %b",
						seen, got.empty_res, want.empty_res));
				if (got.occupancy !== want.occupancy)
					report_mismatch($sformatf("beat %0d occupancy %0d, expected %0d",
						seen, got.occupancy, want.occupancy));
			end
		end
	end

	initial begin
		op_t op;
		int  pick;
		int  push_pct;
		push_pct = 65;

		add_row(spq_pkg::MODE_POP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{spq_pkg::STATUS_POP_EMPTY, 16'h0000, 1'b0, 1'b1, 5'd0});
		add_row(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{spq_pkg::STATUS_OK, 16'h0000, 1'b0, 1'b1, 5'd0});
		add_row(spq_pkg::MODE_FIND, 16'h0000, 32'h0000_0000, 1'b1,
			'{spq_pkg::STATUS_OK, 16'h0000, 1'b0, 1'b1, 5'd0});
		add_row(spq_pkg::MODE_PUSH, 16'h0000, 32'hFFFF_FFFF, 1'b1,
			'{spq_pkg::STATUS_OK, 16'h0000, 1'b0, 1'b0, 5'd1});
		add_row(spq_pkg::MODE_PUSH, 16'hFFFF, 32'h0000_0000);
		add_row(spq_pkg::MODE_PUSH, 16'h5555, 32'h0000_0000);
		add_row(spq_pkg::MODE_PUSH, 16'hAAAA, 32'h0000_0000);
		add_row(spq_pkg::MODE_PUSH, 16'h0001, 32'h0000_0007);
		add_row(spq_pkg::MODE_PUSH, 16'h8000, 32'h8000_0000);
		add_row(spq_pkg::MODE_PUSH, 16'h7FFF, 32'h7FFF_FFFF);
		add_row(spq_pkg::MODE_PUSH, 16'h1234, 32'h0000_0007);
		add_row(spq_pkg::MODE_PUSH, 16'h4321, 32'h0000_0003);
		add_row(spq_pkg::MODE_PUSH, 16'h00FF, 32'hFFFF_FFFE);
		add_row(spq_pkg::MODE_PUSH, 16'hFF00, 32'h0000_0001);
		add_row(spq_pkg::MODE_PUSH, 16'h0F0F, 32'h0000_0003);
		add_row(spq_pkg::MODE_PUSH, 16'hF0F0, 32'hFFFF_FFFF);
		add_row(spq_pkg::MODE_PUSH, 16'h3C3C, 32'h0000_0010);
		add_row(spq_pkg::MODE_PUSH, 16'hC3C3, 32'h0000_0002);
		add_row(spq_pkg::MODE_PUSH, 16'h0002, 32'h0000_0007);
		// The queue is full here; a duplicate is flagged ahead of the full check.
		add_row(spq_pkg::MODE_PUSH, 16'h5555, 32'h0000_0001, 1'b1,
			'{spq_pkg::STATUS_DUPLICATE, 16'h0000, 1'b0, 1'b0, 5'd16});
		add_row(spq_pkg::MODE_PUSH, 16'h9999, 32'h0000_0000, 1'b1,
			'{spq_pkg::STATUS_PUSH_FULL, 16'h0000, 1'b0, 1'b0, 5'd16});
		add_row(spq_pkg::MODE_FIND, 16'hFFFF, 32'h0000_0000, 1'b1,
			'{spq_pkg::STATUS_OK, 16'h0000, 1'b1, 1'b0, 5'd16});
		// Three entries tie at priority zero and must leave in push order.
		add_row(spq_pkg::MODE_POP, 16'h0000, 32'h0000_0000, 1'b1,
			'{spq_pkg::STATUS_OK, 16'hFFFF, 1'b0, 1'b0, 5'd15});
		add_row(spq_pkg::MODE_POP, 16'h0000, 32'h0000_0000);
		add_row(spq_pkg::MODE_POP, 16'h0000, 32'h0000_0000);

		foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_op(directed[i].op, directed[i].typed, directed[i].want);

		// Phases alternate between push-heavy and pop-heavy traffic so that the
		// queue swings between full and empty many times.
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % PHASE_LEN == 0) begin
				push_pct = ((k / PHASE_LEN) % 2 == 1) ? 30 : 65;
				tx_steady = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < push_pct) op.mode = spq_pkg::MODE_PUSH;
			else if (pick < 85) op.mode = spq_pkg::MODE_POP;
			else if (pick < 97) op.mode = spq_pkg::MODE_FIND;
			else op.mode = MODE_UNUSED;
			if ($urandom_range(0, 9) == 0) op.id = ID_W'($urandom);
			else op.id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			case ($urandom_range(0, 3))
				0: op.prio = PRIO_W'($urandom);
				1: op.prio = PRIO_W'($urandom_range(0, 3));
				2: op.prio = '1 - PRIO_W'($urandom_range(0, 3));
				default: op.prio = PRIO_W'($urandom_range(0, 15));
			endcase
			send_op(op, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d operations: %0d push, %0d pop, %0d find, %0d unused mode; peak %0d.",
			n_push + n_pop + n_find + n_other, n_push, n_pop, n_find, n_other, peak_occ);
		$display("Saw %0d full and %0d duplicate pushes, %0d empty pops, %0d find hits; %0d errors.",
			n_full, n_dup, n_empty_pop, n_hit, mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/spq_scan.sv
design/stable_priority_queue.sv
design/spq_checker.sv
tb/stable_priority_queue_tb.sv
